[sv/cft_pkg.sv]
// Shared types and constants for the call/return function tracer.
// Used by cft_table, cft_scan and call_return_function_tracer_top; depends on nothing.
`default_nettype none

package cft_pkg;

    // Default table depth.
    localparam int MAX_ENTRIES_DEF = 64;

    // Fixed field widths of the data words.
    localparam int ADDR_W   = 32;
    localparam int REG_W    = 5;
    localparam int EVENT_W  = 3;
    localparam int INDEX_W  = 6;
    localparam int INDENT_W = 15;
    localparam int DEPTH_W  = 16;

    // Register number of the return-address register.
    localparam logic [REG_W-1:0] RA_REG   = 5'd1;
    localparam logic [REG_W-1:0] ZERO_REG = 5'd0;

    // Function codes of an input word.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_TRACE = 1'b1;

    // Saturation bounds of the signed call depth.
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7FFF;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -16'sh8000;

    // Event codes of a result word.
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 3'd0,
        EV_CALL   = 3'd1,
        EV_RET    = 3'd2,
        EV_MISS   = 3'd3,
        EV_STORED = 3'd4,
        EV_FULL   = 3'd5
    } t_event;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Status handed from the scan unit to the sequencer.
    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_stat;

endpackage : cft_pkg

`default_nettype wire

[sv/call_return_function_tracer_top.sv]
// Call/return function tracer: a table of function ranges plus a small sequencer
// that classifies jumps and looks them up. Depends on cft_pkg, cft_table and cft_scan.
//
// One input word is taken at a time; o_stall is high from acceptance until the result
// has moved into the output register. A load word, and a trace word that is neither
// call nor return, pass from ST_DECODE straight to ST_EMIT. A call or return walks the
// table through one comparator fed by the single read port, one entry per cycle, and
// stops at the first match or once every loaded entry is tested. A result that cannot
// move into a full output register waits in ST_EMIT. The result waits in the output
// register while the next word is accepted. The table has no reset; only entries
// already loaded are read.
`default_nettype none

module call_return_function_tracer_top #(
    parameter int MAX_ENTRIES = cft_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_func,
    input  wire logic [cft_pkg::ADDR_W-1:0]      i_entry_start,
    input  wire logic [cft_pkg::ADDR_W-1:0]      i_entry_end,
    input  wire logic [cft_pkg::ADDR_W-1:0]      i_inst_addr,
    input  wire logic [cft_pkg::ADDR_W-1:0]      i_target_addr,
    input  wire logic [cft_pkg::REG_W-1:0]       i_src_reg,
    input  wire logic [cft_pkg::REG_W-1:0]       i_dest_reg,
    input  wire logic [cft_pkg::ADDR_W-1:0]      i_offset_imm,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [cft_pkg::EVENT_W-1:0]     o_event_kind,
    output logic      [cft_pkg::INDEX_W-1:0]     o_entry_index,
    output logic      [cft_pkg::ADDR_W-1:0]      o_entry_first,
    output logic      [cft_pkg::INDENT_W-1:0]    o_indent_level
);
    import cft_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);

    // Sequencer and architectural state.
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [DEPTH_W-1:0] r_depth, n_depth;

    // Latched input word.
    logic                      r_func;
    logic [ADDR_W-1:0]         r_start, r_end, r_iaddr, r_taddr, r_imm;
    logic [REG_W-1:0]          r_src, r_dest;

    // Pending result and scan key.
    logic                      r_is_ret, n_is_ret;
    logic [ADDR_W-1:0]         r_key, n_key;
    t_event                    r_res_kind, n_res_kind;
    logic [INDEX_W-1:0]        r_res_idx, n_res_idx;
    logic [ADDR_W-1:0]         r_res_first, n_res_first;
    logic [INDENT_W-1:0]       r_res_indent, n_res_indent;

    // Output register.
    logic                      r_out_valid, n_out_valid;
    logic                      out_load;

    // Table and scan connections.
    logic                      wr_en;
    logic                      scan_start;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic [ADDR_W-1:0]         rd_first, rd_limit;
    t_scan_stat                scan_stat;
    logic [IDX_W-1:0]          scan_idx;
    logic [ADDR_W-1:0]         scan_first;

    logic                      in_accept;
    logic                      is_ret, is_call;

    assign in_accept = i_valid && !o_stall;
    assign o_stall   = (r_state != ST_IDLE);

    cft_table #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_count[IDX_W-1:0]),
        .i_wr_first (r_start),
        .i_wr_limit (r_end),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_first (rd_first),
        .o_rd_limit (rd_limit)
    );

    cft_scan #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scan_start),
        .i_key      (r_key),
        .i_count    (r_count),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_first (rd_first),
        .i_rd_limit (rd_limit),
        .o_stat     (scan_stat),
        .o_idx      (scan_idx),
        .o_first    (scan_first)
    );

    // Jump classification; the return test takes priority over the call test.
    always_comb begin
        is_ret  = (r_src == RA_REG) && (r_dest == ZERO_REG) && (r_imm == '0);
        is_call = (r_dest != ZERO_REG);
    end

    // Sequencer: next state, table write, scan start and result forming.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_depth      = r_depth;
        n_is_ret     = r_is_ret;
        n_key        = r_key;
        n_res_kind   = r_res_kind;
        n_res_idx    = r_res_idx;
        n_res_first  = r_res_first;
        n_res_indent = r_res_indent;
        wr_en        = 1'b0;
        scan_start   = 1'b0;
        out_load     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_res_kind   = EV_NONE;
                n_res_idx    = '0;
                n_res_first  = '0;
                n_res_indent = '0;
                n_state      = ST_EMIT;
                if (r_func == FUNC_LOAD) begin
                    if (r_count == FULL_COUNT) begin
                        n_res_kind = EV_FULL;
                    end else begin
                        wr_en       = 1'b1;
                        n_res_kind  = EV_STORED;
                        n_res_idx   = INDEX_W'(r_count);
                        n_res_first = r_start;
                        n_count     = r_count + CNT_W'(1);
                    end
                end else if (is_ret || is_call) begin
                    n_is_ret   = is_ret;
                    n_key      = is_ret ? r_iaddr : r_taddr;
                    scan_start = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_stat.done) begin
                    n_state = ST_EMIT;
                    if (!scan_stat.hit) begin
                        n_res_kind = EV_MISS;
                    end else if (r_is_ret) begin
                        n_res_kind   = EV_RET;
                        n_res_idx    = INDEX_W'(scan_idx);
                        n_res_first  = scan_first;
                        n_res_indent = (r_depth > 16'sd1) ?
                                       INDENT_W'(r_depth - 16'sd1) : '0;
                        if (r_depth != DEPTH_MIN) begin
                            n_depth = r_depth - 16'sd1;
                        end
                    end else begin
                        n_res_kind   = EV_CALL;
                        n_res_idx    = INDEX_W'(scan_idx);
                        n_res_first  = scan_first;
                        n_res_indent = (r_depth > 16'sd0) ? INDENT_W'(r_depth) : '0;
                        if (r_depth != DEPTH_MAX) begin
                            n_depth = r_depth + 16'sd1;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register valid: set on a load, cleared when the word is taken.
    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func  <= i_func;
            r_start <= i_entry_start;
            r_end   <= i_entry_end;
            r_iaddr <= i_inst_addr;
            r_taddr <= i_target_addr;
            r_src   <= i_src_reg;
            r_dest  <= i_dest_reg;
            r_imm   <= i_offset_imm;
        end
        r_is_ret     <= n_is_ret;
        r_key        <= n_key;
        r_res_kind   <= n_res_kind;
        r_res_idx    <= n_res_idx;
        r_res_first  <= n_res_first;
        r_res_indent <= n_res_indent;
        if (out_load) begin
            o_event_kind   <= r_res_kind;
            o_entry_index  <= r_res_idx;
            o_entry_first  <= r_res_first;
            o_indent_level <= r_res_indent;
        end
    end

    assign o_valid = r_out_valid;

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count exceeds table depth");

    // A table write never happens with the table full.
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_count != FULL_COUNT))
        else $error("table written while full");

    // The scan unit reports completion only while the sequencer waits for it.
    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_stat.done |-> (r_state == ST_SCAN))
        else $error("scan completion outside scan state");

    // A word loaded into a busy output register would overwrite an unsent result.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || !i_stall))
        else $error("output register overwritten");

endmodule : call_return_function_tracer_top

`default_nettype wire

[sv/cft_table.sv]
// Function range table: start and limit memories, one write port, one registered read port.
// Depends on cft_pkg for the address width.
`default_nettype none

module cft_table #(
    parameter int MAX_ENTRIES = cft_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_wr_en,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0]    i_wr_addr,
    input  wire logic [cft_pkg::ADDR_W-1:0]        i_wr_first,
    input  wire logic [cft_pkg::ADDR_W-1:0]        i_wr_limit,
    input  wire logic                              i_rd_en,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0]    i_rd_addr,
    output logic      [cft_pkg::ADDR_W-1:0]        o_rd_first,
    output logic      [cft_pkg::ADDR_W-1:0]        o_rd_limit
);
    import cft_pkg::*;

    logic [ADDR_W-1:0] r_mem_first [MAX_ENTRIES];
    logic [ADDR_W-1:0] r_mem_limit [MAX_ENTRIES];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_first[i_wr_addr] <= i_wr_first;
            r_mem_limit[i_wr_addr] <= i_wr_limit;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_first <= r_mem_first[i_rd_addr];
            o_rd_limit <= r_mem_limit[i_rd_addr];
        end
    end

endmodule : cft_table

`default_nettype wire

[sv/cft_scan.sv]
// Range scan unit: walks the table one entry a cycle through a single range comparator.
// Depends on cft_pkg for widths and the status struct.
`default_nettype none

module cft_scan #(
    parameter int MAX_ENTRIES = cft_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [cft_pkg::ADDR_W-1:0]          i_key,
    input  wire logic [$clog2(MAX_ENTRIES+1)-1:0]    i_count,
    output logic                                     o_rd_en,
    output logic      [$clog2(MAX_ENTRIES)-1:0]      o_rd_addr,
    input  wire logic [cft_pkg::ADDR_W-1:0]          i_rd_first,
    input  wire logic [cft_pkg::ADDR_W-1:0]          i_rd_limit,
    output cft_pkg::t_scan_stat                      o_stat,
    output logic      [$clog2(MAX_ENTRIES)-1:0]      o_idx,
    output logic      [cft_pkg::ADDR_W-1:0]          o_first
);
    import cft_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic             r_busy;
    logic             r_cmp_v;
    logic [CNT_W-1:0] r_next;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_done;
    logic             r_hit;
    logic [IDX_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_first;

    logic key_match;
    logic found;
    logic exhausted;
    logic issue;
    logic finish;

    // The shared comparator tests the entry read in the previous cycle.
    always_comb begin
        key_match = (i_key >= i_rd_first) && (i_key < i_rd_limit);
        found     = r_cmp_v && key_match;
        exhausted = !r_cmp_v && (r_next >= i_count);
        issue     = r_busy && !found && (r_next < i_count);
        finish    = r_busy && (found || exhausted);
    end

    assign o_rd_en   = issue;
    assign o_rd_addr = r_next[IDX_W-1:0];

    // Scan control: issue reads while entries remain, stop at the first hit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cmp_v <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= finish;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cmp_v <= 1'b0;
            end else if (finish) begin
                r_busy  <= 1'b0;
                r_cmp_v <= 1'b0;
            end else begin
                r_cmp_v <= issue;
            end
        end
    end

    // Scan position and captured result.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_next <= '0;
        end else if (issue) begin
            r_next    <= r_next + CNT_W'(1);
            r_cmp_idx <= r_next[IDX_W-1:0];
        end
        if (finish) begin
            r_hit   <= found;
            r_idx   <= r_cmp_idx;
            r_first <= i_rd_first;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.hit  = r_hit;
    assign o_idx       = r_idx;
    assign o_first     = r_first;

endmodule : cft_scan

`default_nettype wire
